// ===== rtl/prac_pkg.sv =====
// prac_pkg: shared widths, payload and config structs, queue entry and
// CORDIC stage types, register indexes and the arctangent table.
// No dependencies; every other file of the point rotator imports it.
package prac_pkg;

	// coordinate and angle widths
	localparam int COORD_BITS    = 12;
	localparam int ANGLE_BITS    = 16;

	// internal arithmetic widths
	localparam int TURN_BITS     = 32;
	localparam int ZW            = TURN_BITS + 1;
	localparam int XW            = 33;
	localparam int CORDIC_STAGES = 30;
	localparam int TRIG_BITS     = 16;
	localparam int FRAC_BITS     = 15;
	localparam int DIFF_BITS     = COORD_BITS + 1;
	localparam int PROD_BITS     = DIFF_BITS + TRIG_BITS;
	localparam int SUM_BITS      = PROD_BITS + 2;

	// decoupling queue
	localparam int QDEPTH        = 2;
	localparam int QIDX_BITS     = $clog2(QDEPTH);

	// configuration port
	localparam int PADDR_BITS    = 4;
	localparam int PDATA_BITS    = 32;
	localparam int REG_IDX_BITS  = 2;
	localparam int STEP_IN_BITS  = 16;

	localparam logic [REG_IDX_BITS-1:0] REG_CENTER_X   = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_CENTER_Y   = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_ANGLE_STEP = 2'd2;

	localparam logic signed [COORD_BITS-1:0] CENTER_X_RST   = COORD_BITS'(400);
	localparam logic signed [COORD_BITS-1:0] CENTER_Y_RST   = COORD_BITS'(300);
	localparam logic        [ANGLE_BITS-1:0] ANGLE_STEP_RST = ANGLE_BITS'(52);

	// CORDIC gain in Q2.30
	localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] rotated_x;
		logic signed [COORD_BITS-1:0] rotated_y;
		logic        [ANGLE_BITS-1:0] current_angle;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic        [ANGLE_BITS-1:0] angle_step;
	} cfg_t;

	// classified tick waiting for the back end
	typedef struct packed {
		logic signed [ZW-1:0]        z;
		logic                        flip;
		logic signed [DIFF_BITS-1:0] dx;
		logic signed [DIFF_BITS-1:0] dy;
		logic        [ANGLE_BITS-1:0] angle;
	} qent_t;

	// one CORDIC pipeline stage
	typedef struct packed {
		logic signed [XW-1:0]        x;
		logic signed [XW-1:0]        y;
		logic signed [ZW-1:0]        z;
		logic                        flip;
		logic signed [DIFF_BITS-1:0] dx;
		logic signed [DIFF_BITS-1:0] dy;
		logic        [ANGLE_BITS-1:0] angle;
	} cor_t;

	// atan(2^-i) in 2^-32 turn units
	function automatic logic [TURN_BITS-1:0] atan_turn(input int unsigned i);
		case (i)
			0:       return 32'h20000000;
			1:       return 32'h12E4051D;
			2:       return 32'h09FB385B;
			3:       return 32'h051111D4;
			4:       return 32'h028B0D43;
			5:       return 32'h0145D7E1;
			6:       return 32'h00A2F61E;
			7:       return 32'h00517C55;
			8:       return 32'h0028BE53;
			9:       return 32'h00145F2E;
			10:      return 32'h000A2F98;
			11:      return 32'h000517CC;
			12:      return 32'h00028BE6;
			13:      return 32'h000145F3;
			14:      return 32'h0000A2F9;
			15:      return 32'h0000517C;
			16:      return 32'h000028BE;
			17:      return 32'h0000145F;
			18:      return 32'h00000A2F;
			19:      return 32'h00000517;
			20:      return 32'h0000028B;
			21:      return 32'h00000145;
			22:      return 32'h000000A2;
			23:      return 32'h00000051;
			24:      return 32'h00000028;
			25:      return 32'h00000014;
			26:      return 32'h0000000A;
			27:      return 32'h00000005;
			28:      return 32'h00000002;
			29:      return 32'h00000001;
			default: return '0;
		endcase
	endfunction

endpackage

// ===== rtl/prac_regs.sv =====
// prac_regs: APB-style configuration registers (center and angle step).
// Depends on prac_pkg for the config struct, register indexes and resets.
module prac_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [prac_pkg::PADDR_BITS-1:0] paddr,
	input  logic [prac_pkg::PDATA_BITS-1:0] pwdata,
	output logic [prac_pkg::PDATA_BITS-1:0] prdata,
	output logic                            pready,
	output prac_pkg::cfg_t                  cfg
);
	import prac_pkg::*;

	cfg_t                           cfg_q;
	logic                           wr_en;
	logic [REG_IDX_BITS-1:0]        reg_idx;
	logic [PDATA_BITS-1:0]          step_masked;
	logic signed [PDATA_BITS-1:0]   cx_ext;
	logic signed [PDATA_BITS-1:0]   cy_ext;

	assign pready      = 1'b1;
	assign wr_en       = psel && penable && pwrite;
	assign reg_idx     = paddr[PADDR_BITS-1:2];
	assign step_masked = {{(PDATA_BITS-STEP_IN_BITS){1'b0}}, pwdata[STEP_IN_BITS-1:0]};
	assign cfg         = cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x   <= CENTER_X_RST;
			cfg_q.center_y   <= CENTER_Y_RST;
			cfg_q.angle_step <= ANGLE_STEP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CENTER_X:   cfg_q.center_x   <= pwdata[COORD_BITS-1:0];
				REG_CENTER_Y:   cfg_q.center_y   <= pwdata[COORD_BITS-1:0];
				REG_ANGLE_STEP: cfg_q.angle_step <= step_masked[ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	assign cx_ext = cfg_q.center_x;
	assign cy_ext = cfg_q.center_y;

	always_comb begin
		unique case (reg_idx)
			REG_CENTER_X:   prdata = cx_ext;
			REG_CENTER_Y:   prdata = cy_ext;
			REG_ANGLE_STEP: prdata = PDATA_BITS'(cfg_q.angle_step);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== rtl/prac_front.sv =====
// prac_front: accepts ticks, steps the angle accumulator, folds the angle
// into the CORDIC range and forms the offsets from the center.
// Depends on prac_pkg; feeds the decoupling queue.
module prac_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  prac_pkg::in_item_t in_item,
	input  prac_pkg::cfg_t     cfg,
	input  logic               q_full,
	output logic               q_push,
	output prac_pkg::qent_t    q_data
);
	import prac_pkg::*;

	logic [ANGLE_BITS-1:0]        acc_q;
	logic [ANGLE_BITS-1:0]        ang_next;
	logic [TURN_BITS-1:0]         a32;
	logic [TURN_BITS-1:0]         z32;
	logic                         flip;
	logic signed [DIFF_BITS-1:0]  px_w;
	logic signed [DIFF_BITS-1:0]  py_w;
	logic signed [DIFF_BITS-1:0]  cx_w;
	logic signed [DIFF_BITS-1:0]  cy_w;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// accumulator lowered by the step on every transfer
	assign ang_next = acc_q - cfg.angle_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (q_push) begin
			acc_q <= ang_next;
		end
	end

	// quadrants 1 and 2 lose half a turn and flip the result sign
	assign a32  = TURN_BITS'(ang_next) << (TURN_BITS - ANGLE_BITS);
	assign flip = a32[TURN_BITS-1] ^ a32[TURN_BITS-2];
	assign z32  = {a32[TURN_BITS-1] ^ flip, a32[TURN_BITS-2:0]};

	// offsets from the center
	assign px_w = in_item.point_x;
	assign py_w = in_item.point_y;
	assign cx_w = cfg.center_x;
	assign cy_w = cfg.center_y;

	always_comb begin
		q_data.z     = {z32[TURN_BITS-1], z32};
		q_data.flip  = flip;
		q_data.dx    = px_w - cx_w;
		q_data.dy    = py_w - cy_w;
		q_data.angle = ang_next;
	end

endmodule

// ===== rtl/prac_fifo.sv =====
// prac_fifo: short queue of classified ticks between front and back end.
// Depends on prac_pkg for the entry type and depth.
module prac_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  prac_pkg::qent_t wdata,
	input  logic            pop,
	output prac_pkg::qent_t rdata,
	output logic            full,
	output logic            empty
);
	import prac_pkg::*;

	qent_t                 mem_q [QDEPTH];
	logic [QIDX_BITS-1:0]  wr_ptr_q;
	logic [QIDX_BITS-1:0]  rd_ptr_q;
	logic [QIDX_BITS:0]    cnt_q;

	assign full  = (cnt_q == (QIDX_BITS+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/prac_back.sv =====
// prac_back: 30-stage CORDIC pipeline, Q1.15 rounding, rotation products,
// sums and saturation, with the output register. Stalls as one unit.
// Depends on prac_pkg for widths, stage types and the arctangent table.
module prac_back (
	input  logic                clk,
	input  logic                arst_n,
	input  prac_pkg::cfg_t      cfg,
	input  logic                q_empty,
	input  prac_pkg::qent_t     q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output prac_pkg::out_item_t out_item
);
	import prac_pkg::*;

	localparam logic signed [XW-1:0]       TRIG_MAX  = XW'(32767);
	localparam logic signed [XW-1:0]       TRIG_MIN  = -XW'(32767);
	localparam logic signed [XW-1:0]       RND_HALF  = XW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUM_BITS-1:0] DIV_BIAS  = (SUM_BITS'(1) <<< FRAC_BITS) - 1;
	localparam logic signed [SUM_BITS-1:0] CRD_MAX   = (SUM_BITS'(1) <<< (COORD_BITS-1)) - 1;
	localparam logic signed [SUM_BITS-1:0] CRD_MIN   = -(SUM_BITS'(1) <<< (COORD_BITS-1));

	logic  adv;
	cor_t  cor_head;
	cor_t  cor_s1     [CORDIC_STAGES];
	logic  cor_vld_s1 [CORDIC_STAGES];

	logic                         trig_vld_s2;
	logic signed [TRIG_BITS-1:0]  cos_s2;
	logic signed [TRIG_BITS-1:0]  sin_s2;
	logic signed [DIFF_BITS-1:0]  dx_s2;
	logic signed [DIFF_BITS-1:0]  dy_s2;
	logic        [ANGLE_BITS-1:0] ang_s2;

	logic                         prod_vld_s3;
	logic signed [PROD_BITS-1:0]  dxc_s3;
	logic signed [PROD_BITS-1:0]  dys_s3;
	logic signed [PROD_BITS-1:0]  dxs_s3;
	logic signed [PROD_BITS-1:0]  dyc_s3;
	logic        [ANGLE_BITS-1:0] ang_s3;

	logic                         sum_vld_s4;
	logic signed [SUM_BITS-1:0]   sx_s4;
	logic signed [SUM_BITS-1:0]   sy_s4;
	logic        [ANGLE_BITS-1:0] ang_s4;

	logic signed [SUM_BITS-1:0]   cx_w;
	logic signed [SUM_BITS-1:0]   cy_w;

	logic      out_valid_q;
	out_item_t out_item_q;

	// whole pipeline moves unless the output holds an untaken result
	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv && !q_empty;

	// CORDIC start vector
	always_comb begin
		cor_head.x     = CORDIC_GAIN;
		cor_head.y     = '0;
		cor_head.z     = q_data.z;
		cor_head.flip  = q_data.flip;
		cor_head.dx    = q_data.dx;
		cor_head.dy    = q_data.dy;
		cor_head.angle = q_data.angle;
	end

	// one micro-rotation per stage
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cor
		cor_t                  cin;
		cor_t                  cnx;
		logic                  vin;
		logic signed [XW-1:0]  xs;
		logic signed [XW-1:0]  ys;
		logic signed [ZW-1:0]  tz;

		if (g == 0) begin : g_first
			assign cin = cor_head;
			assign vin = !q_empty;
		end else begin : g_next
			assign cin = cor_s1[g-1];
			assign vin = cor_vld_s1[g-1];
		end

		assign xs = cin.x >>> g;
		assign ys = cin.y >>> g;
		assign tz = {1'b0, atan_turn(g)};

		always_comb begin
			cnx = cin;
			if (!cin.z[ZW-1]) begin
				cnx.x = cin.x - ys;
				cnx.y = cin.y + xs;
				cnx.z = cin.z - tz;
			end else begin
				cnx.x = cin.x + ys;
				cnx.y = cin.y - xs;
				cnx.z = cin.z + tz;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cor_s1[g] <= cnx;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cor_vld_s1[g] <= 1'b0;
			end else if (adv) begin
				cor_vld_s1[g] <= vin;
			end
		end
	end

	// round to Q1.15, clamp, undo the half-turn fold
	function automatic logic signed [TRIG_BITS-1:0] to_q15(
		input logic signed [XW-1:0] v,
		input logic                 neg
	);
		logic signed [XW-1:0]        r;
		logic signed [TRIG_BITS-1:0] t;
		r = (v + RND_HALF) >>> FRAC_BITS;
		if (r > TRIG_MAX) begin
			r = TRIG_MAX;
		end else if (r < TRIG_MIN) begin
			r = TRIG_MIN;
		end
		t = r[TRIG_BITS-1:0];
		return neg ? -t : t;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_s2 <= to_q15(cor_s1[CORDIC_STAGES-1].x, cor_s1[CORDIC_STAGES-1].flip);
			sin_s2 <= to_q15(cor_s1[CORDIC_STAGES-1].y, cor_s1[CORDIC_STAGES-1].flip);
			dx_s2  <= cor_s1[CORDIC_STAGES-1].dx;
			dy_s2  <= cor_s1[CORDIC_STAGES-1].dy;
			ang_s2 <= cor_s1[CORDIC_STAGES-1].angle;
		end
	end

	// rotation products
	always_ff @(posedge clk) begin
		if (adv) begin
			dxc_s3 <= dx_s2 * cos_s2;
			dys_s3 <= dy_s2 * sin_s2;
			dxs_s3 <= dx_s2 * sin_s2;
			dyc_s3 <= dy_s2 * cos_s2;
			ang_s3 <= ang_s2;
		end
	end

	// add the center back in Q.15
	assign cx_w = cfg.center_x;
	assign cy_w = cfg.center_y;

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s4  <= (cx_w <<< FRAC_BITS) + dxc_s3 - dys_s3;
			sy_s4  <= (cy_w <<< FRAC_BITS) + dxs_s3 + dyc_s3;
			ang_s4 <= ang_s3;
		end
	end

	// divide by 2^15 toward zero, then saturate
	function automatic logic signed [COORD_BITS-1:0] trunc_sat(
		input logic signed [SUM_BITS-1:0] s
	);
		logic signed [SUM_BITS-1:0] q;
		q = (s + (s[SUM_BITS-1] ? DIV_BIAS : SUM_BITS'(0))) >>> FRAC_BITS;
		if (q > CRD_MAX) begin
			q = CRD_MAX;
		end else if (q < CRD_MIN) begin
			q = CRD_MIN;
		end
		return q[COORD_BITS-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			out_item_q.rotated_x     <= trunc_sat(sx_s4);
			out_item_q.rotated_y     <= trunc_sat(sy_s4);
			out_item_q.current_angle <= ang_s4;
		end
	end

	// stage valid bits behind the CORDIC bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_vld_s2 <= 1'b0;
			prod_vld_s3 <= 1'b0;
			sum_vld_s4  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			trig_vld_s2 <= cor_vld_s1[CORDIC_STAGES-1];
			prod_vld_s3 <= trig_vld_s2;
			sum_vld_s4  <= prod_vld_s3;
			out_valid_q <= sum_vld_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== rtl/point_rotator_about_center_core.sv =====
// Rotates points about a programmable center by a stepping angle.
// Input channel in_valid/in_ready/in_item carries one tick with a point;
// each transfer lowers a 16-bit turn accumulator by angle_step and rotates
// the point by the new angle. Output channel out_valid/out_ready/out_item
// returns the rotated point and the angle used, one result per tick, in
// order. Registers over the APB-style port: center_x at 0x0, center_y at
// 0x4, angle_step at 0x8; write them only while the block is empty.
// From input transfer to output valid a tick passes the queue entry
// written at the transfer, then 30 CORDIC stages, rounding, products, sums
// and the output register. Throughput is one tick per cycle while the
// output is not stalled, set by the fully unrolled CORDIC pipeline; the only
// value carried between ticks is the accumulator, stepped on each transfer.
// When out_ready is low with a result waiting, the back-end pipeline holds
// as a whole; the two-entry queue then fills and in_ready drops.
// Reset clears the accumulator, queue and all valid bits, and loads the
// register defaults center (400, 300) and step 52. No clearing pass.
// Depends on prac_pkg, prac_regs, prac_front, prac_fifo and prac_back.
module point_rotator_about_center_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  prac_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output prac_pkg::out_item_t             out_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [prac_pkg::PADDR_BITS-1:0] paddr,
	input  logic [prac_pkg::PDATA_BITS-1:0] pwdata,
	output logic [prac_pkg::PDATA_BITS-1:0] prdata,
	output logic                            pready
);
	import prac_pkg::*;

	cfg_t  cfg;
	qent_t q_wdata;
	qent_t q_rdata;
	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;

	// configuration registers
	prac_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// tick intake and angle classification
	prac_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cfg      (cfg),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	// decoupling queue
	prac_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// rotation pipeline
	prac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/prac_checker.sv =====
// prac_checker: port-level assertions for the point rotator, bound to the
// top level. Depends on prac_pkg and point_rotator_about_center_core.
module prac_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  prac_pkg::in_item_t              in_item,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  prac_pkg::out_item_t             out_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [prac_pkg::PADDR_BITS-1:0] paddr,
	input  logic [prac_pkg::PDATA_BITS-1:0] pwdata,
	input  logic [prac_pkg::PDATA_BITS-1:0] prdata,
	input  logic                            pready
);
	import prac_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped before transfer");

	// a full queue drains whenever the output is not stalled
	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !(out_valid && !out_ready) |=> in_ready)
		else $error("input stalled with no output backpressure");

	// the queue only fills from an input transfer or output stall
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(in_valid && in_ready) || $past(out_valid && !out_ready))
		else $error("input stall without cause");

endmodule

bind point_rotator_about_center_core prac_checker u_prac_checker (.*);

// ===== tb/sv/rotation_checker.sv =====
`timescale 1ns / 100ps
// rotation_checker: watches the tick, result and register ports of the point rotator,
// predicts each rotated point with its own CORDIC model and compares results in order.
// Depends on prac_pkg for payload types, widths and register indexes.
module rotation_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  prac_pkg::in_item_t              in_item,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  prac_pkg::out_item_t             out_item,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [prac_pkg::PADDR_BITS-1:0] paddr,
	input  logic [prac_pkg::PDATA_BITS-1:0] pwdata,
	output int                              mismatches,
	output int                              outstanding
);

	localparam int     CBITS     = prac_pkg::COORD_BITS;
	localparam int     ABITS     = prac_pkg::ANGLE_BITS;
	localparam int     ROT_ITERS = 30;
	localparam longint GAIN_Q30  = 652032874;
	localparam longint HALF_TURN = 64'sd2147483648;
	localparam longint FULL_TURN = 64'sd4294967296;
	localparam longint TRIG_MAX  = 32767;
	localparam longint CRD_HI    = (64'sd1 <<< (CBITS - 1)) - 1;
	localparam longint CRD_LO    = -(64'sd1 <<< (CBITS - 1));

	localparam logic signed [CBITS-1:0] HOME_X    = CBITS'(400);
	localparam logic signed [CBITS-1:0] HOME_Y    = CBITS'(300);
	localparam logic        [ABITS-1:0] HOME_STEP = ABITS'(52);

	// arctangent of 2^-i in 2^-32 turn units
	longint arctan_step [ROT_ITERS] = '{
		'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43,
		'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E,
		'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2F9,
		'h0000517C, 'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
		'h0000028B, 'h00000145, 'h000000A2, 'h00000051, 'h00000028,
		'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001
	};

	// shadow of the registers and the turn accumulator
	logic signed [CBITS-1:0] center_x_q;
	logic signed [CBITS-1:0] center_y_q;
	logic        [ABITS-1:0] step_q;
	logic        [ABITS-1:0] angle_q;

	prac_pkg::out_item_t rotated_q [$];
	int errs = 0;

	// round a Q2.30 value to Q1.15, symmetric clamp
	function automatic longint round_q15(input longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > TRIG_MAX)
			r = TRIG_MAX;
		if (r < -TRIG_MAX)
			r = -TRIG_MAX;
		return r;
	endfunction

	// sine and cosine of a turn angle, folded into the right half plane
	function automatic void cordic_trig(input logic [ABITS-1:0] ang,
			output longint sin_q, output longint cos_q);
		logic [31:0] turn;
		longint      x;
		longint      y;
		longint      z;
		longint      xs;
		longint      ys;
		logic        flip;
		turn = 32'(ang) << (32 - ABITS);
		x    = GAIN_Q30;
		y    = 0;
		z    = {32'h0, turn};
		flip = 1'b0;
		case (turn[31:30])
			2'b01, 2'b10: begin
				z    = z - HALF_TURN;
				flip = 1'b1;
			end
			2'b11: begin
				z = z - FULL_TURN;
			end
			default: ;
		endcase
		for (int i = 0; i < ROT_ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_step[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_step[i];
			end
		end
		cos_q = round_q15(x);
		sin_q = round_q15(y);
		if (flip) begin
			cos_q = -cos_q;
			sin_q = -sin_q;
		end
	endfunction

	function automatic logic [CBITS-1:0] clamp_coord(input longint v);
		if (v > CRD_HI)
			v = CRD_HI;
		if (v < CRD_LO)
			v = CRD_LO;
		return CBITS'(v);
	endfunction

	// rotate one point about the current center by the given angle
	function automatic prac_pkg::out_item_t rotate_about_center(
			input prac_pkg::in_item_t pt, input logic [ABITS-1:0] ang);
		longint              s;
		longint              c;
		longint              px;
		longint              py;
		longint              cx;
		longint              cy;
		longint              dx;
		longint              dy;
		prac_pkg::out_item_t r;
		cordic_trig(ang, s, c);
		px = pt.point_x;
		py = pt.point_y;
		cx = center_x_q;
		cy = center_y_q;
		dx = px - cx;
		dy = py - cy;
		r.rotated_x     = clamp_coord((cx * 32768 + dx * c - dy * s) / 32768);
		r.rotated_y     = clamp_coord((cy * 32768 + dx * s + dy * c) / 32768);
		r.current_angle = ang;
		return r;
	endfunction

	// track register writes, predict on tick transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		prac_pkg::out_item_t                want;
		logic [prac_pkg::REG_IDX_BITS-1:0] reg_idx;
		if (!arst_n) begin
			center_x_q = HOME_X;
			center_y_q = HOME_Y;
			step_q     = HOME_STEP;
			angle_q    = '0;
			rotated_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				reg_idx = paddr[2 +: prac_pkg::REG_IDX_BITS];
				case (reg_idx)
					prac_pkg::REG_CENTER_X:   center_x_q = pwdata[CBITS-1:0];
					prac_pkg::REG_CENTER_Y:   center_y_q = pwdata[CBITS-1:0];
					prac_pkg::REG_ANGLE_STEP: step_q     = pwdata[ABITS-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				angle_q = angle_q - step_q;
				rotated_q.push_back(rotate_about_center(in_item, angle_q));
			end
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					errs++;
					$display("%0t: unexpected result: expected none, got x=%0d y=%0d angle=%0d",
						$time, out_item.rotated_x, out_item.rotated_y,
						out_item.current_angle);
				end else begin
					want = rotated_q.pop_front();
					if (out_item.rotated_x !== want.rotated_x) begin
						errs++;
						$display("%0t: rotated_x expected %0d, got %0d",
							$time, want.rotated_x, out_item.rotated_x);
					end
					if (out_item.rotated_y !== want.rotated_y) begin
						errs++;
						$display("%0t: rotated_y expected %0d, got %0d",
							$time, want.rotated_y, out_item.rotated_y);
					end
					if (out_item.current_angle !== want.current_angle) begin
						errs++;
						$display("%0t: current_angle expected %0d, got %0d",
							$time, want.current_angle, out_item.current_angle);
					end
				end
			end
		end
		mismatches  <= errs;
		outstanding <= rotated_q.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: drives ticks and register writes into point_rotator_about_center_core
// under random stalls and reports the verdict. Depends on prac_pkg and rotation_checker.
module tb_top;
	import prac_pkg::*;

	localparam int LATENCY     = 35;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEG_POINTS  = 133;

	localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [PADDR_BITS-1:0] paddr     = '0;
	logic [PDATA_BITS-1:0] pwdata    = '0;
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	int mismatches;
	int outstanding;
	int send_idle = 23;
	int recv_idle = 66;
	int cycle_cnt = 0;

	point_rotator_about_center_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	rotation_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// runaway guard
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("point_rotator_about_center_core regression: fail");
		$finish;
	end

	// setup then access phase; pready ends the access
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// one tick transfer, with optional idle cycles in front
	task automatic send_point(input int px, input int py);
		in_item_t p;
		p.point_x = COORD_BITS'(px);
		p.point_y = COORD_BITS'(py);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random_point();
		int px;
		int py;
		px = $urandom_range(4095);
		py = $urandom_range(4095);
		// pin a coordinate to a range limit now and then
		if ($urandom_range(7) == 0)
			px = $urandom_range(1) ? 2047 : -2048;
		if ($urandom_range(7) == 0)
			py = $urandom_range(1) ? 2047 : -2048;
		send_point(px, py);
	endtask

	// stop ticking and wait for every predicted result to leave
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// random center anywhere, step small, near a full turn, or anything; sometimes an unmapped write
	task automatic randomize_registers();
		logic [31:0] step_word;
		step_word = $urandom();
		case ($urandom_range(3))
			0: step_word[15:0] = 16'($urandom_range(1, 64));
			1: step_word[15:0] = 16'(65536 - $urandom_range(1, 64));
			default: ;
		endcase
		write_reg(REG_CENTER_X, $urandom());
		write_reg(REG_CENTER_Y, $urandom());
		write_reg(REG_ANGLE_STEP, step_word);
		if ($urandom_range(3) == 0)
			write_reg(REG_UNMAPPED, $urandom());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: coordinate corners, origin, the center itself;
		// the first tick wraps the angle below zero
		send_point(-2048, -2048);
		send_point(2047, 2047);
		send_point(-2048, 2047);
		send_point(2047, -2048);
		send_point(0, 0);
		send_point(400, 300);
		wait_drained();

		// undo the six default ticks so the angle lands on zero,
		// with junk above the step field
		write_reg(REG_ANGLE_STEP, {16'hBEEF, 16'(-6 * 52)});
		send_point(100, -100);
		wait_drained();

		// corner center, quarter-turn steps hit every quadrant boundary and saturate;
		// unmapped index must not disturb anything
		write_reg(REG_CENTER_X, 32'h5A5A_F800);
		write_reg(REG_CENTER_Y, 32'hA5A5_07FF);
		write_reg(REG_ANGLE_STEP, 32'hDEAD_4000);
		write_reg(REG_UNMAPPED, 32'h0000_0123);
		repeat (4) send_point(2047, -2048);
		wait_drained();

		// opposite corner center, zero step
		write_reg(REG_CENTER_X, 32'hFFFF_F7FF);
		write_reg(REG_CENTER_Y, 32'h0000_0800);
		write_reg(REG_ANGLE_STEP, 32'hFFFF_0000);
		send_point(-2048, 2047);
		send_point(0, 0);
		send_point(2047, 2047);
		wait_drained();

		// origin center, largest step walks the angle upward
		write_reg(REG_CENTER_X, 32'h0000_0000);
		write_reg(REG_CENTER_Y, 32'h0000_0000);
		write_reg(REG_ANGLE_STEP, 32'h0000_FFFF);
		send_point(-2048, -2048);
		send_point(2047, 0);
		send_point(0, 2047);
		send_point(1, -1);

		// random phases: receiver-heavy idling, sender-heavy idling, none
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 23;
					recv_idle = 66;
				end
				1: begin
					send_idle = 66;
					recv_idle = 23;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				wait_drained();
				randomize_registers();
				repeat (SEG_POINTS) send_random_point();
			end
		end

		wait_drained();
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0)
			$display("point_rotator_about_center_core regression: pass");
		else
			$display("point_rotator_about_center_core regression: fail");
		$finish;
	end

endmodule
